// File: rtl/percent_escape_decoder_macros.svh
// Assertion macros for the percent-escape decoder.
// Depends on a clock named clk and an active-low reset named rst_n in the user.
`ifndef PERCENT_ESCAPE_DECODER_MACROS_SVH
`define PERCENT_ESCAPE_DECODER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset.
`define PED_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("percent_escape_decoder check failed");
// Next-cycle implication, disabled in reset.
`define PED_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("percent_escape_decoder check failed");
`else
`define PED_ASSERT_NOW(label, ante, cons)
`define PED_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/ped_pkg.sv
// Shared types, codes and hex helpers for the percent-escape decoder.
// No dependencies.
package ped_pkg;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_PCT    = 2'd1;
    localparam logic [1:0] MODE_DIGIT  = 2'd2;

    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] CTRL_LIMIT = 8'd32;
    localparam logic [7:0] DEL_CODE   = 8'd127;

    localparam int MAX_RESULTS = 3;

    // Decoder outcome for one request: emitted bytes plus the next escape state.
    typedef struct packed {
        logic [1:0]                        count;
        logic [MAX_RESULTS-1:0][7:0]       bytes;
        logic [1:0]                        mode;
        logic [7:0]                        held;
    } ped_result_t;

    function automatic logic hex_valid(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            v = c[3:0];
        end
        else if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

// File: rtl/ped_decode.sv
// Combinational escape decoder: one text byte plus escape state in, up to three bytes out.
// Depends on ped_pkg.
module ped_decode (
    input  logic [1:0]          mode,
    input  logic [7:0]          held,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output ped_pkg::ped_result_t res
);
    import ped_pkg::*;

    logic       c_hex;
    logic [7:0] decoded;
    logic [7:0] value;

    assign c_hex = hex_valid(in_byte);
    assign value = {hex_value(held), hex_value(in_byte)};
    assign decoded = (value < CTRL_LIMIT || value == DEL_CODE) ? SPACE_CHAR : value;

    always_comb
    begin
        res       = '0;
        res.mode  = MODE_NORMAL;
        res.held  = held;
        case (mode)
            MODE_PCT:
            begin
                if (in_byte == PCT_CHAR)
                begin
                    res.bytes[res.count] = PCT_CHAR;
                    res.count = res.count + 2'd1;
                end
                else if (c_hex)
                begin
                    res.held = in_byte;
                    res.mode = MODE_DIGIT;
                end
                else
                begin
                    // Broken escape: emit the percent sign, then the byte as text.
                    res.bytes[res.count] = PCT_CHAR;
                    res.count = res.count + 2'd1;
                    res.bytes[res.count] = in_byte;
                    res.count = res.count + 2'd1;
                end
            end
            MODE_DIGIT:
            begin
                if (c_hex)
                begin
                    res.bytes[res.count] = decoded;
                    res.count = res.count + 2'd1;
                end
                else
                begin
                    res.bytes[res.count] = PCT_CHAR;
                    res.count = res.count + 2'd1;
                    res.bytes[res.count] = held;
                    res.count = res.count + 2'd1;
                    if (in_byte == PCT_CHAR)
                    begin
                        res.mode = MODE_PCT;
                    end
                    else
                    begin
                        res.bytes[res.count] = in_byte;
                        res.count = res.count + 2'd1;
                    end
                end
            end
            default:
            begin
                if (in_byte == PCT_CHAR)
                begin
                    res.mode = MODE_PCT;
                end
                else
                begin
                    res.bytes[res.count] = in_byte;
                    res.count = res.count + 2'd1;
                end
            end
        endcase

        // Flush a pending escape at the end of the text.
        if (in_last)
        begin
            if (res.mode == MODE_PCT)
            begin
                res.bytes[res.count] = PCT_CHAR;
                res.count = res.count + 2'd1;
            end
            else if (res.mode == MODE_DIGIT)
            begin
                res.bytes[res.count] = PCT_CHAR;
                res.count = res.count + 2'd1;
                res.bytes[res.count] = res.held;
                res.count = res.count + 2'd1;
            end
            res.mode = MODE_NORMAL;
        end
    end

endmodule

// File: rtl/percent_escape_decoder.sv
// Top level of the streaming percent-escape decoder.
// Depends on ped_pkg, ped_decode and percent_escape_decoder_macros.svh.
//
//  channel   | direction | payload
//  ----------+-----------+---------------------------------------------
//  s_axis    | in        | tdata = in_byte[7:0], tlast = in_last
//  m_axis    | out       | tdata = out_byte[7:0], tlast = run_last,
//            |           | tuser = text_end
//
// Each request is decoded in the cycle it is accepted and its 0..3 result
// bytes land in a three-entry result buffer that drains one byte per cycle
// while m_axis_tready is high. Plain text streams at one byte per cycle while
// the sink is ready; a request yielding more bytes holds the input until the
// last of them leaves through the single output port draining the buffer.
// Reset clears the escape state and empties the result buffer.
// Output stalls propagate to s_axis_tready through the buffer fill level.
module percent_escape_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,
    output logic       m_axis_tuser    // [0] text_end
);
    import ped_pkg::*;

    `include "percent_escape_decoder_macros.svh"

    // Escape state carried between requests.
    logic [1:0] mode_reg;
    logic [7:0] held_reg;

    // Result buffer: entry 0 is the byte on the output port.
    logic [MAX_RESULTS-1:0][7:0] byte_reg;
    logic [1:0]                  cnt_reg;
    logic                        end_reg;

    ped_result_t dec_res;
    logic        in_fire;
    logic        out_fire;

    ped_decode u_decode (
        .mode    (mode_reg),
        .held    (held_reg),
        .in_byte (s_axis_tdata),
        .in_last (s_axis_tlast),
        .res     (dec_res)
    );

    // Take a new request when the buffer is empty or its final byte leaves now.
    assign s_axis_tready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_axis_tready);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = byte_reg[0];
    assign m_axis_tlast  = (cnt_reg == 2'd1);
    assign m_axis_tuser  = (cnt_reg == 2'd1) && end_reg;
    assign out_fire      = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            held_reg <= 8'd0;
            cnt_reg  <= 2'd0;
            end_reg  <= 1'b0;
        end
        else if (in_fire)
        begin
            // Advance the escape state and load this request's results.
            mode_reg <= dec_res.mode;
            held_reg <= dec_res.held;
            cnt_reg  <= dec_res.count;
            end_reg  <= s_axis_tlast;
        end
        else if (out_fire)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Payload of the buffer: load on accept, shift down on each delivered byte.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            byte_reg <= dec_res.bytes;
        end
        else if (out_fire)
        begin
            byte_reg[0] <= byte_reg[1];
            byte_reg[1] <= byte_reg[2];
        end
    end

    // A request that ends the text always leaves at least one byte to deliver.
    `PED_ASSERT_NEXT(a_flush_emits, in_fire && s_axis_tlast, m_axis_tvalid)
    // The end of the text is always flushed back to normal mode.
    `PED_ASSERT_NEXT(a_flush_mode, in_fire && s_axis_tlast, mode_reg == MODE_NORMAL)
    // The text-end marker only ever rides on the last byte of a run.
    `PED_ASSERT_NOW(a_end_on_last, m_axis_tuser, m_axis_tlast)
    // A run that is not finished keeps presenting bytes.
    `PED_ASSERT_NEXT(a_run_continues, out_fire && !m_axis_tlast, m_axis_tvalid)

endmodule

// File: dv/percent_escape_decoder_tb.sv
// Self-checking testbench for percent_escape_decoder: directed escape cases, then random
// escaped text under random stalls on both stream channels. Depends on ped_pkg and the RTL.
module percent_escape_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ped_pkg::*;

    // One decoded byte as it leaves m_axis.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_end;
    } dec_byte_t;

    localparam string HEX_CHARS = "0123456789abcdefABCDEF";

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;  // [7:0] in_byte
    logic       s_axis_tlast = 1'b0;   // in_last
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;          // [7:0] out_byte
    logic       m_axis_tlast;          // run_last
    logic       m_axis_tuser;          // [0] text_end

    percent_escape_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predictor state: escape mode and the first hex digit of an open escape.
    logic [1:0] esc_mode = MODE_NORMAL;
    logic [7:0] held_char = 8'h00;
    dec_byte_t  decoded_bytes [$];

    // Idling knobs, changed between tests.
    bit src_idle = 1'b1;
    int sink_stall_pct = 30;

    int n_requests = 0;
    int n_results = 0;
    int n_text_ends = 0;
    int n_errors = 0;

    // Hex digit value in bits 3:0; bit 4 set means the byte is not a hex digit.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = 8'hFF;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d = c - 8'h30;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d = c - 8'h37;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d = c - 8'h57;
        end
        return (d == 8'hFF) ? 5'h10 : {1'b0, d[3:0]};
    endfunction

    // Handle a byte as ordinary text: a percent sign opens an escape, all else passes.
    task automatic plain_text(input logic [7:0] c, ref logic [7:0] bytes_out [$]);
        if (c == PCT_CHAR)
        begin
            esc_mode = MODE_PCT;
        end
        else
        begin
            bytes_out.push_back(c);
        end
    endtask

    // Advance the predictor by one accepted request and queue the bytes it yields.
    task automatic predict_decode(input logic [7:0] c, input logic last);
        logic [7:0] bytes_out [$];
        logic [4:0] lo;
        logic [4:0] hi;
        logic [7:0] value;
        dec_byte_t  item;
        lo = hex_nibble(c);
        case (esc_mode)
            MODE_PCT:
            begin
                if (c == PCT_CHAR)
                begin
                    // doubled percent collapses to one
                    esc_mode = MODE_NORMAL;
                    bytes_out.push_back(PCT_CHAR);
                end
                else if (!lo[4])
                begin
                    held_char = c;
                    esc_mode = MODE_DIGIT;
                end
                else
                begin
                    esc_mode = MODE_NORMAL;
                    bytes_out.push_back(PCT_CHAR);
                    plain_text(c, bytes_out);
                end
            end
            MODE_DIGIT:
            begin
                esc_mode = MODE_NORMAL;
                if (!lo[4])
                begin
                    hi = hex_nibble(held_char);
                    value = {hi[3:0], lo[3:0]};
                    // decoded control codes turn into spaces
                    if (value < CTRL_LIMIT || value == DEL_CODE)
                    begin
                        value = SPACE_CHAR;
                    end
                    bytes_out.push_back(value);
                end
                else
                begin
                    // broken escape: replay percent and digit, then the byte as text
                    bytes_out.push_back(PCT_CHAR);
                    bytes_out.push_back(held_char);
                    plain_text(c, bytes_out);
                end
            end
            default:
            begin
                esc_mode = MODE_NORMAL;
                plain_text(c, bytes_out);
            end
        endcase
        // end of text flushes whatever escape is still open
        if (last)
        begin
            if (esc_mode == MODE_PCT)
            begin
                bytes_out.push_back(PCT_CHAR);
            end
            else if (esc_mode == MODE_DIGIT)
            begin
                bytes_out.push_back(PCT_CHAR);
                bytes_out.push_back(held_char);
            end
            esc_mode = MODE_NORMAL;
        end
        foreach (bytes_out[k])
        begin
            item.out_byte = bytes_out[k];
            item.run_last = (k == bytes_out.size() - 1);
            item.text_end = item.run_last && last;
            decoded_bytes.push_back(item);
        end
    endtask

    // Mostly short gaps, a few long ones.
    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Sink: stall at random with the current stall rate.
    int sink_stall_left = 0;
    always @(posedge clk)
    begin
        if (sink_stall_left > 0)
        begin
            sink_stall_left = sink_stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < sink_stall_pct)
        begin
            sink_stall_left = gap_len() - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Sample the output channel mid-cycle, when it is settled, and check at the edge.
    bit        out_fire = 1'b0;
    dec_byte_t out_seen;
    always @(negedge clk)
    begin
        out_fire = rst_n && m_axis_tvalid && m_axis_tready;
        out_seen = '{out_byte: m_axis_tdata, run_last: m_axis_tlast, text_end: m_axis_tuser};
    end

    always @(posedge clk)
    begin
        dec_byte_t want;
        if (out_fire)
        begin
            n_results++;
            if (out_seen.text_end)
            begin
                n_text_ends++;
            end
            if (decoded_bytes.size() == 0)
            begin
                $error("unexpected result: out_byte %02h run_last %0b text_end %0b",
                       out_seen.out_byte, out_seen.run_last, out_seen.text_end);
                n_errors++;
            end
            else
            begin
                want = decoded_bytes.pop_front();
                if (out_seen.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %02h, actual %02h",
                           want.out_byte, out_seen.out_byte);
                    n_errors++;
                end
                if (out_seen.run_last !== want.run_last)
                begin
                    $error("run_last: expected %0b, actual %0b",
                           want.run_last, out_seen.run_last);
                    n_errors++;
                end
                if (out_seen.text_end !== want.text_end)
                begin
                    $error("text_end: expected %0b, actual %0b",
                           want.text_end, out_seen.text_end);
                    n_errors++;
                end
            end
        end
    end

    // Send one request. Enter and leave at a rising edge; the request counts as taken
    // once tready is seen high at a falling edge while tvalid is asserted.
    task automatic send_request(input logic [7:0] b, input logic last);
        int  gap;
        bit  taken;
        gap = (src_idle && $urandom_range(0, 99) < 35) ? gap_len() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            if (s_axis_tready)
            begin
                taken = 1'b1;
                n_requests++;
                predict_decode(b, last);
            end
            @(posedge clk);
        end
    endtask

    // Send a string byte by byte, optionally flagging its final byte as end of text.
    task automatic send_text(input string s, input bit last_at_end);
        for (int i = 0; i < s.len(); i++)
        begin
            send_request(s[i], last_at_end && (i == s.len() - 1));
        end
    endtask

    // Drop tvalid and hold off until every queued result byte has been seen.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (decoded_bytes.size() != 0);
    endtask

    function automatic logic [7:0] rand_hex();
        return HEX_CHARS[$urandom_range(0, HEX_CHARS.len() - 1)];
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] b;
        logic [4:0] n;
        do
        begin
            b = 8'($urandom_range(0, 255));
            n = hex_nibble(b);
        end
        while (!n[4]);
        return b;
    endfunction

    function automatic logic rand_last(input int pct);
        return ($urandom_range(0, 99) < pct);
    endfunction

    // Random escaped text: half well-formed escapes with random digits, the rest plain
    // bytes, doubled percents and broken escapes. End of text falls at random positions.
    task automatic send_random_text(input int n_items, input int last_pct);
        int sent;
        int kind;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 50)
            begin
                send_request(PCT_CHAR, rand_last(last_pct));
                send_request(rand_hex(), rand_last(last_pct));
                send_request(rand_hex(), rand_last(last_pct));
                sent += 3;
            end
            else if (kind < 65)
            begin
                send_request(8'($urandom_range(0, 255)), rand_last(last_pct));
                sent += 1;
            end
            else if (kind < 75)
            begin
                send_request(PCT_CHAR, rand_last(last_pct));
                send_request(PCT_CHAR, rand_last(last_pct));
                sent += 2;
            end
            else if (kind < 85)
            begin
                send_request(PCT_CHAR, rand_last(last_pct));
                send_request(rand_non_hex(), rand_last(last_pct));
                sent += 2;
            end
            else if (kind < 95)
            begin
                // byte after the first digit is a percent or a non-hex byte
                send_request(PCT_CHAR, rand_last(last_pct));
                send_request(rand_hex(), rand_last(last_pct));
                send_request(($urandom_range(0, 3) == 0) ? PCT_CHAR : rand_non_hex(),
                             rand_last(last_pct));
                sent += 3;
            end
            else
            begin
                // text ends inside an escape
                send_request(PCT_CHAR, 1'b0);
                send_request(rand_hex(), 1'b1);
                sent += 2;
            end
        end
    endtask

    task automatic test_directed_cases();
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        send_text("%Ff", 1'b0);    // both letter cases, top value
        send_text("%1F", 1'b0);    // control code becomes space
        send_text("%7f", 1'b0);    // delete code becomes space
        send_text("%%", 1'b0);     // doubled percent
        send_text("%g", 1'b0);     // percent then non-hex
        send_text("%4%41", 1'b0);  // second percent opens a new escape
        send_text("%3z", 1'b0);    // break off after one digit
        send_text("%", 1'b1);      // flush after percent only
        send_text("%b", 1'b1);     // flush after one digit
        drain_results();
    endtask

    task automatic test_random_stream();
        send_random_text(230, 6);
        send_request(8'h41, 1'b1);
        drain_results();
    endtask

    task automatic test_drain_pause();
        send_random_text(40, 8);
        drain_results();
        send_random_text(40, 8);
        drain_results();
    endtask

    task automatic test_heavy_backpressure();
        sink_stall_pct = 75;
        send_random_text(50, 8);
        drain_results();
        sink_stall_pct = 30;
    endtask

    task automatic test_back_to_back();
        src_idle = 1'b0;
        sink_stall_pct = 0;
        send_random_text(50, 8);
        send_request(PCT_CHAR, 1'b1);
        drain_results();
        src_idle = 1'b1;
        sink_stall_pct = 30;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_stream();
        test_drain_pause();
        test_heavy_backpressure();
        test_back_to_back();

        // let any late output show up
        repeat (16) @(posedge clk);

        $display("Covered %0d requests, %0d decoded bytes and %0d text ends,",
                 n_requests, n_results, n_text_ends);
        $display("including broken and flushed escapes under random stalls on both sides.");
        if (n_errors == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #(5_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule
